/* rtl/mva_pkg.sv */
// shared types and constants for the modular vector alu
// no dependencies; imported by mva_modred, modular_vector_alu_top, mva_checker and tb

package mva_pkg;

  // field and operand widths
  localparam int DATA_W = 16;
  localparam int OPND_W = 2 * DATA_W;
  localparam int STEPS  = OPND_W;
  localparam int CNT_W  = $clog2(STEPS);

  // modulus register
  localparam logic [DATA_W-1:0] MOD_RESET   = DATA_W'(2);
  localparam logic              REG_MODULUS = 1'b0;

  // command codes
  typedef enum logic [3:0] {
    CMD_ADD    = 4'd0,
    CMD_SUB    = 4'd1,
    CMD_MULCW  = 4'd2,
    CMD_SCALE  = 4'd3,
    CMD_SUBMUL = 4'd4,
    CMD_INC    = 4'd5,
    CMD_ROTNZ  = 4'd6,
    CMD_NEG    = 4'd7,
    CMD_DOT    = 4'd8,
    CMD_EQUAL  = 4'd9,
    CMD_ISNONE = 4'd10
  } cmd_t;

  // request to the serial reducer
  typedef struct packed {
    logic              start;
    logic [OPND_W-1:0] operand;
    logic [DATA_W-1:0] divisor;
  } mred_req_t;

  // reply from the serial reducer
  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] residue;
  } mred_resp_t;

endpackage

/* rtl/mva_modred.sv */
// bit-serial restoring reduction of a 32-bit operand by a 16-bit divisor
// depends on mva_pkg for widths and the request/reply structs

module mva_modred (
  input  logic               clk,
  input  logic               rst,
  input  mva_pkg::mred_req_t  req,
  output mva_pkg::mred_resp_t resp
);
  import mva_pkg::*;

  logic              busy;
  logic              done;
  logic [CNT_W-1:0]  cnt;
  logic [OPND_W-1:0] xs;
  logic [DATA_W-1:0] d;
  logic [DATA_W-1:0] r;
  logic [DATA_W:0]   t;
  logic [DATA_W-1:0] r_next;

  // one restoring step: shift in the next operand bit, subtract if it fits
  always_comb begin
    t      = {r, xs[OPND_W-1]};
    r_next = t[DATA_W-1:0];
    if (t >= {1'b0, d}) begin
      r_next = DATA_W'(t - {1'b0, d});
    end
  end

  // step counter and shift register
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        xs   <= req.operand;
        d    <= req.divisor;
        r    <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        xs  <= xs << 1;
        r   <= r_next;
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign resp.done    = done;
  assign resp.residue = r;

  // a new operand only arrives when the reducer is free
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !busy) else $error("reducer started while busy");

  // a zero divisor would never reduce
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    req.start |-> req.divisor != '0) else $error("zero divisor");

  // the residue is always below the divisor
  a_residue_range: assert property (@(posedge clk) disable iff (rst)
    done |-> r < d) else $error("residue not reduced");

  // done follows the final step
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("done without a run");

endmodule

/* rtl/modular_vector_alu_top.sv */
// top level of the modular vector alu: input decode, sequencer, state, output register
// depends on mva_pkg and mva_modred

// usage
//   input stream s_*: tdata = cell_a, cell_b, scalar; tuser = cmd; tlast = last_in
//   output stream m_*: tdata = value; tuser = flag; tlast = last_out
//   apb port: one register, modulus at byte address 0; values below 2 act as 2
// timing
//   an item is taken only in the idle state; arithmetic items run the serial
//   reducer for 32 steps, one operand bit per cycle
//   single-pass commands: the residue is registered, then loaded into the
//   output register; the next item can be accepted in the cycle after the load
//   submul and dot need two reducer passes
//   equal, isnone on 0 or 1 and rotnz on 0 need no reducer pass; unused
//   codes are dropped
// reset and stall
//   rst (synchronous) clears the sequencer, the output valid and the dot
//   accumulator, sets the equal/isnone flags to 1, and sets modulus to 2
//   a stalled result stays in the output register; the next item is accepted
//   and worked on meanwhile, and its result waits until the register frees

module modular_vector_alu_top (
  input  logic        clk,
  input  logic        rst,
  // input item stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // cell_a [15:0], cell_b [31:16], scalar [47:32]
  input  logic [3:0]  s_tuser,   // cmd [3:0]
  input  logic        s_tlast,
  // result item stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // value [15:0]
  output logic        m_tuser,   // flag [0]
  output logic        m_tlast,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mva_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } state_t;

  state_t            state;
  logic [DATA_W-1:0] modulus;
  logic [DATA_W-1:0] n_eff;
  logic [DATA_W-1:0] acc;
  logic              eq_so_far;
  logic              none_so_far;
  cmd_t              cmd_q;
  logic [DATA_W-1:0] a_q;
  logic              last_q;
  logic              pass_q;
  logic [DATA_W-1:0] res_value;
  logic              res_flag;
  mred_req_t         req;
  mred_resp_t        resp;

  cmd_t              s_cmd;
  logic [DATA_W-1:0] s_a;
  logic [DATA_W-1:0] s_b;
  logic [DATA_W-1:0] s_s;
  logic [DATA_W-1:0] mul_l;
  logic [DATA_W-1:0] mul_r;
  logic [OPND_W-1:0] prod;
  logic [OPND_W-1:0] x1;
  logic [DATA_W-1:0] d1;
  logic              eq_next;
  logic              none_imm;
  logic              none_run;
  logic              cfg_wr;

  // input fields
  assign s_cmd = cmd_t'(s_tuser);
  assign s_a   = s_tdata[15:0];
  assign s_b   = s_tdata[31:16];
  assign s_s   = s_tdata[47:32];

  // effective modulus, at least 2
  assign n_eff = (modulus < DATA_W'(2)) ? DATA_W'(2) : modulus;

  // single product for the multiplying commands
  assign mul_l = (s_cmd == CMD_SUBMUL) ? s_s : s_a;
  assign mul_r = (s_cmd == CMD_SCALE) ? s_s : s_b;
  assign prod  = OPND_W'(mul_l) * OPND_W'(mul_r);

  // first-pass operand and divisor; n shifted up is a multiple of n
  always_comb begin
    x1 = prod;
    d1 = n_eff;
    unique case (s_cmd) inside
      CMD_ADD:    x1 = OPND_W'(s_a) + OPND_W'(s_b);
      CMD_SUB:    x1 = {n_eff, {DATA_W{1'b0}}} + OPND_W'(s_a) - OPND_W'(s_b);
      CMD_INC:    x1 = OPND_W'(s_a) + OPND_W'(1);
      CMD_NEG:    x1 = {n_eff, {DATA_W{1'b0}}} - OPND_W'(s_a);
      CMD_ROTNZ: begin
        x1 = OPND_W'(s_a);
        d1 = n_eff - DATA_W'(1);
      end
      CMD_ISNONE: begin
        x1 = OPND_W'(n_eff);
        d1 = s_a;
      end
      default: x1 = prod;
    endcase
  end

  // running flags
  assign eq_next  = eq_so_far & (s_a == s_b);
  assign none_imm = none_so_far & (s_a != DATA_W'(1));
  assign none_run = none_so_far & (resp.residue == '0);

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign prdata = (paddr[2] == REG_MODULUS) ? {{(32-DATA_W){1'b0}}, modulus} : '0;
  assign s_tready = (state == S_IDLE);

  // sequencer, state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      modulus     <= MOD_RESET;
      acc         <= '0;
      eq_so_far   <= 1'b1;
      none_so_far <= 1'b1;
      m_tvalid    <= 1'b0;
      req.start   <= 1'b0;
      pass_q      <= 1'b0;
    end else begin
      req.start <= 1'b0;
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_wr && paddr[2] == REG_MODULUS) begin
        modulus <= pwdata[DATA_W-1:0];
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            cmd_q       <= s_cmd;
            a_q         <= s_a;
            last_q      <= s_tlast;
            pass_q      <= 1'b0;
            req.operand <= x1;
            req.divisor <= d1;
            res_value   <= '0;
            res_flag    <= 1'b0;
            unique case (s_cmd) inside
              CMD_ADD, CMD_SUB, CMD_MULCW, CMD_SCALE, CMD_SUBMUL, CMD_INC, CMD_NEG,
              CMD_DOT: begin
                req.start <= 1'b1;
                state     <= S_RUN;
              end
              CMD_ROTNZ: begin
                if (s_a == '0) begin
                  state <= S_DONE;
                end else begin
                  req.start <= 1'b1;
                  state     <= S_RUN;
                end
              end
              CMD_EQUAL: begin
                if (s_tlast) begin
                  res_flag  <= eq_next;
                  eq_so_far <= 1'b1;
                  state     <= S_DONE;
                end else begin
                  eq_so_far <= eq_next;
                end
              end
              CMD_ISNONE: begin
                // zero passes, one fails, larger values test n mod a
                if (s_a <= DATA_W'(1)) begin
                  if (s_tlast) begin
                    res_flag    <= none_imm;
                    none_so_far <= 1'b1;
                    state       <= S_DONE;
                  end else begin
                    none_so_far <= none_imm;
                  end
                end else begin
                  req.start <= 1'b1;
                  state     <= S_RUN;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_RUN: begin
          if (resp.done) begin
            res_value <= resp.residue;
            res_flag  <= 1'b0;
            unique case (cmd_q) inside
              CMD_SUBMUL: begin
                if (!pass_q) begin
                  req.start   <= 1'b1;
                  req.operand <= {n_eff, {DATA_W{1'b0}}} + OPND_W'(a_q)
                                 - OPND_W'(resp.residue);
                  pass_q      <= 1'b1;
                end else begin
                  state <= S_DONE;
                end
              end
              CMD_DOT: begin
                if (!pass_q) begin
                  req.start   <= 1'b1;
                  req.operand <= OPND_W'(acc) + OPND_W'(resp.residue);
                  pass_q      <= 1'b1;
                end else if (last_q) begin
                  acc   <= '0;
                  state <= S_DONE;
                end else begin
                  acc   <= resp.residue;
                  state <= S_IDLE;
                end
              end
              CMD_ISNONE: begin
                res_value <= '0;
                if (last_q) begin
                  res_flag    <= none_run;
                  none_so_far <= 1'b1;
                  state       <= S_DONE;
                end else begin
                  none_so_far <= none_run;
                  state       <= S_IDLE;
                end
              end
              CMD_ROTNZ: begin
                res_value <= resp.residue + DATA_W'(1);
                state     <= S_DONE;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= res_value;
            m_tuser  <= res_flag;
            m_tlast  <= last_q;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  mva_modred u_modred (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .resp (resp)
  );

  // the reducer only finishes while the sequencer waits for it
  a_done_in_run: assert property (@(posedge clk) disable iff (rst)
    resp.done |-> state == S_RUN) else $error("reducer done outside run");

  // a delivered value is a residue of the current modulus
  a_value_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata < n_eff) else $error("result not reduced");

  // flag results carry a zero value
  a_flag_value: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> m_tdata == '0) else $error("flag result with value");

  // no new item while the reducer runs
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    req.start |=> !s_tready) else $error("item taken during a reduction");

endmodule

/* sim/mva_checker.sv */
// result checker for the modular vector alu: tracks the modulus register, predicts each
// result item from the accepted input items and compares it with the output stream
// depends on mva_pkg

`timescale 1ns / 100ps

module mva_checker (
  input  logic        clk,
  input  logic        rst,
  // input item stream
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [47:0] s_tdata,   // cell_a [15:0], cell_b [31:16], scalar [47:32]
  input  logic [3:0]  s_tuser,   // cmd [3:0]
  input  logic        s_tlast,
  // result item stream
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,   // value [15:0]
  input  logic        m_tuser,   // flag [0]
  input  logic        m_tlast,
  // configuration writes
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  // status to the testbench top
  output int          fail_count,
  output int          outstanding
);
  import mva_pkg::*;

  localparam logic [2:0] MOD_ADDR = 3'(4 * REG_MODULUS);

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              flag;
    logic              last;
  } alu_result_t;

  // predicted results not yet seen on the output
  alu_result_t residue_q[$];

  // shadow of the register and of the reduction state
  logic [DATA_W-1:0] modulus;
  logic [DATA_W-1:0] dot_acc;
  logic              equal_acc;
  logic              none_acc;
  int                n_fail;

  // one input item through the alu; returns 1 when it yields a result item
  function automatic bit modular_op(input logic [3:0] cmd, input logic [15:0] a,
                                    input logic [15:0] b, input logic [15:0] sc,
                                    input logic last, output alu_result_t res);
    logic [31:0] n;
    logic [31:0] am;
    logic [31:0] bm;
    logic [31:0] sm;
    logic        bad;
    res      = '0;
    res.last = last;
    n  = (modulus < 2) ? 32'd2 : 32'(modulus);
    am = a % n;
    bm = b % n;
    sm = sc % n;
    case (cmd)
      CMD_ADD:    res.value = 16'((am + bm) % n);
      CMD_SUB:    res.value = 16'((am + n - bm) % n);
      CMD_MULCW:  res.value = 16'((am * bm) % n);
      CMD_SCALE:  res.value = 16'((am * sm) % n);
      CMD_SUBMUL: res.value = 16'((am + n - (sm * bm) % n) % n);
      CMD_INC:    res.value = 16'((am + 1) % n);
      CMD_ROTNZ:  res.value = (a == 0) ? 16'd0 : 16'((32'(a) % (n - 1)) + 1);
      CMD_NEG:    res.value = 16'((n - am) % n);
      CMD_DOT: begin
        dot_acc = 16'((32'(dot_acc) % n + am * bm) % n);
        if (!last) return 1'b0;
        res.value = dot_acc;
        dot_acc   = '0;
      end
      CMD_EQUAL: begin
        equal_acc = equal_acc && (a == b);
        if (!last) return 1'b0;
        res.flag  = equal_acc;
        equal_acc = 1'b1;
      end
      CMD_ISNONE: begin
        // a nonzero cell that is one or does not divide n breaks the property
        bad      = (a != 0) && ((a == 1) || ((n % 32'(a)) != 0));
        none_acc = none_acc && !bad;
        if (!last) return 1'b0;
        res.flag = none_acc;
        none_acc = 1'b1;
      end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  // count a failure, report the first few
  function automatic void check_field(input string what, input int want, input int got);
    if (want != got) begin
      n_fail++;
      if (n_fail <= 10)
        $display("mismatch on %s at %0t: expected %0h, got %0h", what, $realtime, want, got);
    end
  endfunction

  // watch the channels at each edge
  always @(posedge clk) begin
    alu_result_t res;
    alu_result_t want;
    if (rst) begin
      modulus   = MOD_RESET;
      dot_acc   = '0;
      equal_acc = 1'b1;
      none_acc  = 1'b1;
      n_fail    = 0;
      residue_q.delete();
    end else begin
      // register writes
      if (psel && penable && pwrite && pready && paddr == MOD_ADDR)
        modulus = pwdata[DATA_W-1:0];
      // accepted input item
      if (s_tvalid && s_tready) begin
        if (modular_op(s_tuser, s_tdata[15:0], s_tdata[31:16], s_tdata[47:32], s_tlast, res))
          residue_q.push_back(res);
      end
      // accepted result item
      if (m_tvalid && m_tready) begin
        if (residue_q.size() == 0) begin
          check_field("unexpected result item", 0, 1);
        end else begin
          want = residue_q.pop_front();
          check_field("value", want.value, m_tdata);
          check_field("flag", want.flag, m_tuser);
          check_field("last", want.last, m_tlast);
        end
      end
    end
    fail_count  <= n_fail;
    outstanding <= residue_q.size();
  end

endmodule

/* sim/tb.sv */
// testbench top for the modular vector alu: clock, reset, stimulus, output stalls and verdict
// depends on mva_pkg, modular_vector_alu_top and mva_checker

`timescale 1ns / 100ps

module tb;
  import mva_pkg::*;

  localparam int         LIMIT        = 600_000;
  localparam int         SETTLE       = 120;
  localparam int         HOLD_CYCLES  = 400;
  localparam int         PHASE_ITEMS  = 50;
  localparam int         NUM_PHASES   = 12;
  localparam logic [2:0] MOD_ADDR     = 3'(4 * REG_MODULUS);
  localparam logic [3:0] CMD_UNUSED   = CMD_ISNONE + 4'd1;
  localparam logic [3:0] CMD_MAX_CODE = 4'hF;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata  = '0;
  logic [3:0]  s_tuser  = '0;
  logic        s_tlast  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int outstanding;
  int cycles    = 0;
  int items_fed = 0;
  bit idle_on   = 1'b1;
  bit hold_req  = 1'b0;

  always #5 clk = ~clk;

  modular_vector_alu_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  mva_checker u_chk (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        m_tready <= !idle_on || ($urandom_range(0, 99) >= 38);
      end
    end
  end

  // offer one item, with a random gap first, and wait for its acceptance
  task automatic send_item(input logic [3:0] cmd, input logic [15:0] a, input logic [15:0] b,
                           input logic [15:0] sc, input logic last);
    while (idle_on && $urandom_range(0, 99) < 38) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {sc, b, a};
    s_tuser  <= cmd;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    if (cmd <= CMD_ISNONE) items_fed++;
  endtask

  // wait for every predicted result, then let any resultless work finish
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // register write: setup cycle then access cycle
  task automatic write_modulus(input logic [15:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MOD_ADDR;
    pwdata  <= 32'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // element value: mostly residues, some extremes, some raw values that may exceed n
  function automatic logic [15:0] rand_cell(input int n);
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return 16'($urandom_range(0, n - 1));
    if (r < 85) return r[0] ? 16'(n - 1) : 16'd0;
    return 16'($urandom_range(0, 65534));
  endfunction

  // isnone element: zero, one, small divisors of n, n itself, or anything
  function automatic logic [15:0] divisor_cell(input int n);
    int r;
    int k;
    r = $urandom_range(0, 99);
    k = $urandom_range(2, 20);
    if (r < 10) return 16'd0;
    if (r < 20) return 16'd1;
    if (r < 70 && n % k == 0) return 16'(k);
    if (r < 80 && n <= 65534) return 16'(n);
    return rand_cell(n);
  endfunction

  // one vector: element-wise, a single reduction, mixed commands, or noise
  task automatic random_vector(input int n);
    int          len;
    int          kind;
    logic [3:0]  cmd;
    logic [3:0]  red_cmd;
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] sc;
    logic        last;
    kind    = $urandom_range(0, 99);
    len     = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
    red_cmd = 4'($urandom_range(int'(CMD_DOT), int'(CMD_ISNONE)));
    for (int i = 0; i < len; i++) begin
      if (kind < 40)
        cmd = 4'($urandom_range(int'(CMD_ADD), int'(CMD_NEG)));
      else if (kind < 75)
        cmd = red_cmd;
      else if (kind < 92)
        cmd = 4'($urandom_range(int'(CMD_ADD), int'(CMD_ISNONE)));
      else
        cmd = 4'($urandom_range(int'(CMD_ADD), int'(CMD_MAX_CODE)));
      last = (kind >= 92) ? 1'($urandom_range(0, 1)) : (i == len - 1);
      a    = (cmd == CMD_ISNONE) ? divisor_cell(n) : rand_cell(n);
      b    = (cmd == CMD_EQUAL && $urandom_range(0, 99) < 85) ? a : rand_cell(n);
      sc   = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(0, 65535));
      send_item(cmd, a, b, sc, last);
    end
  endtask

  // stimulus
  initial begin
    int mod_list[NUM_PHASES];
    int mod_n;
    int target;
    mod_list = '{3, 65535, 0, 1, 12, 65521, -1, 2, -1, 256, -1, 65535};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset modulus of two: add, rotate, divisor test and equal at the smallest n
    send_item(CMD_ADD, 16'd1, 16'd1, 16'd0, 1'b1);
    send_item(CMD_ROTNZ, 16'd5, 16'd0, 16'd0, 1'b0);
    send_item(CMD_ISNONE, 16'd1, 16'd0, 16'd0, 1'b1);
    send_item(CMD_EQUAL, 16'd9, 16'd9, 16'd0, 1'b1);
    drain();

    // largest modulus, field extremes, reductions sharing one vector
    write_modulus(16'hFFFF);
    send_item(CMD_ADD, 16'hFFFE, 16'hFFFE, 16'hFFFF, 1'b0);
    send_item(CMD_SUB, 16'd0, 16'hFFFE, 16'd0, 1'b0);
    send_item(CMD_MULCW, 16'hFFFE, 16'hFFFE, 16'd0, 1'b0);
    send_item(CMD_SCALE, 16'hFFFE, 16'd0, 16'hFFFF, 1'b0);
    send_item(CMD_SUBMUL, 16'd5, 16'hFFFE, 16'd0, 1'b0);
    send_item(CMD_SUBMUL, 16'd0, 16'hFFFE, 16'hFFFE, 1'b1);
    send_item(CMD_INC, 16'hFFFE, 16'd0, 16'd0, 1'b0);
    send_item(CMD_ROTNZ, 16'd0, 16'd0, 16'd0, 1'b0);
    send_item(CMD_ROTNZ, 16'hFFFE, 16'd0, 16'd0, 1'b0);
    send_item(CMD_NEG, 16'd0, 16'd0, 16'd0, 1'b0);
    send_item(CMD_NEG, 16'hFFFE, 16'd0, 16'd0, 1'b1);
    send_item(CMD_DOT, 16'hFFFE, 16'hFFFE, 16'd0, 1'b0);
    send_item(CMD_EQUAL, 16'd7, 16'd7, 16'd0, 1'b0);
    send_item(CMD_ISNONE, 16'd0, 16'd0, 16'd0, 1'b0);
    send_item(CMD_ISNONE, 16'd5, 16'd0, 16'd0, 1'b0);
    send_item(CMD_UNUSED, 16'd3, 16'd4, 16'd5, 1'b1);
    send_item(CMD_DOT, 16'hFFFE, 16'd2, 16'd0, 1'b1);
    send_item(CMD_EQUAL, 16'd7, 16'd8, 16'd0, 1'b1);
    send_item(CMD_ISNONE, 16'd3, 16'd0, 16'd0, 1'b1);
    send_item(CMD_MAX_CODE, 16'hFFFE, 16'hFFFE, 16'hFFFF, 1'b0);
    // dot left open across a modulus change
    send_item(CMD_DOT, 16'd1000, 16'd1000, 16'd0, 1'b0);
    drain();
    write_modulus(16'd7);
    send_item(CMD_DOT, 16'd3, 16'd2, 16'd0, 1'b1);
    drain();

    // register values below two act as two
    write_modulus(16'd0);
    send_item(CMD_SUB, 16'd0, 16'hFFFE, 16'd0, 1'b1);
    send_item(CMD_ISNONE, 16'd2, 16'd0, 16'd0, 1'b1);

    // random phases over several moduli
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      mod_n = (mod_list[p] < 0) ? int'($urandom_range(2, 65535)) : mod_list[p];
      write_modulus(16'(mod_n));
      if (mod_n < 2) mod_n = 2;
      idle_on = (p != 5);
      if (p == 8) hold_req = 1'b1;
      target = items_fed + PHASE_ITEMS;
      while (items_fed < target) random_vector(mod_n);
    end
    drain();

    if (fail_count == 0 && outstanding == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
